/* design/can_tx_sorted_queue_defines.svh */
// ----------------------------------------------------------------------------
// CAN transmit sorted queue: assertion macros
// Shared property forms used by the queue's checks, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CAN_TX_SORTED_QUEUE_DEFINES_SVH
`define CAN_TX_SORTED_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define CTSQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("can_tx_sorted_queue: check failed");

// Next-cycle implication.
`define CTSQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("can_tx_sorted_queue: check failed");

`endif

/* design/ctsq_pkg.sv */
// ----------------------------------------------------------------------------
// ctsq_pkg
// Types, codes and sizes shared by the CAN transmit sorted queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ctsq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W   = 29;
  localparam int DLC_W  = 4;
  localparam int DATA_W = 64;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One queued message together with the pool slot it occupies.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic              ext;
    logic              remote;
    logic [DLC_W-1:0]  dlc;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic pop;
    logic flush;
  } cell_ctrl_t;

  typedef struct packed {
    logic              alloc;
    logic              release_slot;
    logic              flush;
    logic [SLOT_W-1:0] rel_slot;
  } alloc_ctrl_t;

endpackage

`default_nettype wire

/* design/ctsq_cell.sv */
// ----------------------------------------------------------------------------
// ctsq_cell
// One position of the sorted shift array. It holds, shifts down on an insert
// ahead of it, loads the new message at the insertion point, shifts up on
// a pop, or clears its valid bit on a flush.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsq_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  ctsq_pkg::cell_ctrl_t         ctrl,
  input  ctsq_pkg::entry_t             new_ent,
  input  ctsq_pkg::entry_t             prev_ent,
  input  wire                          prev_gt,
  input  ctsq_pkg::entry_t             next_ent,
  output ctsq_pkg::entry_t             ent,
  output logic                         gt
);
  import ctsq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // An empty cell counts as greater, so the new message lands in the first
  // empty cell when nothing queued is greater than it.
  assign gt = !ent_r.valid || (ent_r.id > new_ent.id);

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.flush) begin
      ent_nxt.valid = 1'b0;
    end else if (ctrl.pop) begin
      ent_nxt = next_ent;
    end else if (ctrl.insert && gt) begin
      ent_nxt = prev_gt ? prev_ent : new_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.slot   <= ent_nxt.slot;
    ent_r.id     <= ent_nxt.id;
    ent_r.ext    <= ent_nxt.ext;
    ent_r.remote <= ent_nxt.remote;
    ent_r.dlc    <= ent_nxt.dlc;
    ent_r.data   <= ent_nxt.data;
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

/* design/ctsq_slot_alloc.sv */
// ----------------------------------------------------------------------------
// ctsq_slot_alloc
// Pool slot bookkeeping: occupancy bitmap, lowest free slot and fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsq_slot_alloc (
  input  wire                              clk,
  input  wire                              rst_n,
  input  ctsq_pkg::alloc_ctrl_t            ctrl,
  output logic [ctsq_pkg::SLOT_W-1:0]      free_slot,
  output logic                             full,
  output logic [ctsq_pkg::CNT_W-1:0]       count
);
  import ctsq_pkg::*;

  logic [QUEUE_DEPTH-1:0] used_r;
  logic [QUEUE_DEPTH-1:0] used_nxt;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       cnt_nxt;

  always_comb begin
    free_slot = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign count = cnt_r;

  always_comb begin
    used_nxt = used_r;
    cnt_nxt  = cnt_r;
    if (ctrl.flush) begin
      used_nxt = '0;
      cnt_nxt  = '0;
    end else if (ctrl.alloc) begin
      used_nxt[free_slot] = 1'b1;
      cnt_nxt             = cnt_r + CNT_W'(1);
    end else if (ctrl.release_slot) begin
      used_nxt[ctrl.rel_slot] = 1'b0;
      cnt_nxt                 = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      cnt_r  <= '0;
    end else begin
      used_r <= used_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/can_tx_sorted_queue.sv */
// ----------------------------------------------------------------------------
// can_tx_sorted_queue
// Pool of CAN transmit message slots held as a row of cells in ascending
// identifier order; supports insert, pop of the head message, flush and no-op.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   -------   --------------------   ------------------------------------------
//   input     start && !busy         in_action, in_msg_*
//   result    out_valid (1 cycle)    out_status, out_popped_*, out_head_*,
//                                    out_used_count
//
// An item accepted at one edge is latched; at the next edge every cell
// updates at once and the result is registered, so out_valid is high in the
// cycle after that. busy is high for the one cycle in between, and no new item is
// taken while it is. Reset clears the cells' valid bits, the slot bitmap and the
// count. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "can_tx_sorted_queue_defines.svh"

module can_tx_sorted_queue (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire  [1:0]                   in_action,
  input  wire  [28:0]                  in_msg_id,
  input  wire                          in_msg_ext,
  input  wire                          in_msg_remote,
  input  wire  [3:0]                   in_msg_dlc,
  input  wire  [63:0]                  in_msg_data,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [28:0]                  out_popped_id,
  output logic                         out_popped_ext,
  output logic                         out_popped_remote,
  output logic [3:0]                   out_popped_dlc,
  output logic [63:0]                  out_popped_data,
  output logic [2:0]                   out_popped_slot,
  output logic                         out_head_valid,
  output logic [2:0]                   out_head_slot,
  output logic [3:0]                   out_used_count
);
  import ctsq_pkg::*;

  logic              pend_r;
  action_t           act_r;
  logic [ID_W-1:0]   id_r;
  logic              ext_r;
  logic              remote_r;
  logic [DLC_W-1:0]  dlc_r;
  logic [DATA_W-1:0] data_r;

  logic              out_valid_r;
  status_t           status_r;
  entry_t            popped_r;

  entry_t            cell_q   [QUEUE_DEPTH];
  logic              cell_gt  [QUEUE_DEPTH];
  entry_t            prev_ent [QUEUE_DEPTH];
  logic              prev_gt  [QUEUE_DEPTH];
  entry_t            next_ent [QUEUE_DEPTH];

  cell_ctrl_t        cell_ctrl;
  alloc_ctrl_t       alloc_ctrl;
  entry_t            ins_ent;
  logic [SLOT_W-1:0] free_slot;
  logic              full;
  logic [CNT_W-1:0]  cnt;
  status_t           status_nxt;
  logic              pop_ok;

  wire accept = start && !pend_r;

  assign busy = pend_r;

  always_comb begin
    ins_ent.valid  = 1'b1;
    ins_ent.slot   = free_slot;
    ins_ent.id     = id_r;
    ins_ent.ext    = ext_r;
    ins_ent.remote = remote_r;
    ins_ent.dlc    = dlc_r;
    ins_ent.data   = data_r;
  end

  always_comb begin
    cell_ctrl  = '0;
    alloc_ctrl = '0;
    status_nxt = ST_DONE;
    pop_ok     = 1'b0;
    alloc_ctrl.rel_slot = cell_q[0].slot;
    if (pend_r) begin
      unique case (act_r)
        ACT_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cell_ctrl.insert = 1'b1;
            alloc_ctrl.alloc = 1'b1;
          end
        end
        ACT_POP: begin
          if (!cell_q[0].valid) begin
            status_nxt = ST_EMPTY;
          end else begin
            pop_ok                  = 1'b1;
            cell_ctrl.pop           = 1'b1;
            alloc_ctrl.release_slot = 1'b1;
          end
        end
        ACT_FLUSH: begin
          cell_ctrl.flush  = 1'b1;
          alloc_ctrl.flush = 1'b1;
        end
        ACT_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  ctsq_slot_alloc u_alloc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (alloc_ctrl),
    .free_slot (free_slot),
    .full      (full),
    .count     (cnt)
  );

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_ent[i] = '0;
      assign prev_gt[i]  = 1'b0;
    end else begin : g_mid
      assign prev_ent[i] = cell_q[i-1];
      assign prev_gt[i]  = cell_gt[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_ent[i] = '0;
    end else begin : g_inner
      assign next_ent[i] = cell_q[i+1];
    end

    ctsq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .new_ent  (ins_ent),
      .prev_ent (prev_ent[i]),
      .prev_gt  (prev_gt[i]),
      .next_ent (next_ent[i]),
      .ent      (cell_q[i]),
      .gt       (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= accept;
      out_valid_r <= pend_r;
    end
    if (accept) begin
      act_r    <= action_t'(in_action);
      id_r     <= in_msg_id;
      ext_r    <= in_msg_ext;
      remote_r <= in_msg_remote;
      dlc_r    <= in_msg_dlc;
      data_r   <= in_msg_data;
    end
    if (pend_r) begin
      status_r <= status_nxt;
      popped_r <= pop_ok ? cell_q[0] : '0;
    end
  end

  // Head and count are read straight from the cells and the allocator: they
  // change only at the edge that also loads the result registers.
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_popped_id     = popped_r.id;
  assign out_popped_ext    = popped_r.ext;
  assign out_popped_remote = popped_r.remote;
  assign out_popped_dlc    = popped_r.dlc;
  assign out_popped_data   = popped_r.data;
  assign out_popped_slot   = 3'(popped_r.slot);
  assign out_head_valid    = cell_q[0].valid;
  assign out_head_slot     = cell_q[0].valid ? 3'(cell_q[0].slot) : 3'd0;
  assign out_used_count    = 4'(cnt);

  `CTSQ_ASSERT_NEXT(a_result_follows, pend_r, out_valid_r && !pend_r)
  `CTSQ_ASSERT_IMP(a_head_count, 1'b1, cell_q[0].valid == (cnt != '0))
  `CTSQ_ASSERT_NEXT(a_full_drop, pend_r && (act_r == ACT_INSERT) && full, $stable(cnt))

  for (genvar k = 1; k < QUEUE_DEPTH; k++) begin : g_chk
    `CTSQ_ASSERT_IMP(a_sorted, cell_q[k].valid, cell_q[k-1].valid && (cell_q[k-1].id <= cell_q[k].id))
  end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: CAN transmit sorted queue testbench
// Drives insert, pop, flush and no-op items into the queue and keeps a
// behavioural copy of the slot pool and its sorted links. Every result is
// compared field by field with the predicted one, in order of arrival.
// ----------------------------------------------------------------------------

module tb;
  import ctsq_pkg::*;

  localparam int NULL_LINK  = QUEUE_DEPTH;
  localparam int MAX_GAP    = 40;
  localparam int STALL_LIM  = 1000;
  localparam int DRAIN_LIM  = 200;
  localparam int PHASE_LEN  = 225;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              ext;
    logic              remote;
    logic [DLC_W-1:0]  dlc;
    logic [DATA_W-1:0] data;
  } frame_t;

  typedef struct packed {
    status_t           status;
    frame_t            popped;
    logic [SLOT_W-1:0] popped_slot;
    logic              head_valid;
    logic [SLOT_W-1:0] head_slot;
    logic [CNT_W-1:0]  used_count;
  } reply_t;

  // Mirror of the slot pool: occupancy, sorted links and the stored frames.
  class pool_mirror;
    bit     used[QUEUE_DEPTH];
    int     link[QUEUE_DEPTH];
    int     head;
    frame_t store[QUEUE_DEPTH];
    reply_t pending_replies[$];
    int     mismatches;
    int     n_insert, n_full, n_pop, n_empty, n_flush, n_nop, n_checked;

    function new();
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        used[i]  = 1'b0;
        link[i]  = NULL_LINK;
        store[i] = '0;
      end
      head = NULL_LINK;
    endfunction

    function void apply_request(action_t act, frame_t f);
      reply_t r;
      int     slot, p, prev, cnt;
      r = '0;
      r.status = ST_DONE;
      case (act)
        ACT_INSERT: begin
          n_insert++;
          slot = -1;
          for (int i = 0; i < QUEUE_DEPTH; i++)
            if (!used[i] && slot < 0) slot = i;
          if (slot < 0) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            used[slot]  = 1'b1;
            store[slot] = f;
            p = head;
            prev = -1;
            // Walk past every message with a lower or equal identifier, so that
            // equal identifiers leave in the order they arrived.
            while (p != NULL_LINK && store[p].id <= f.id) begin
              prev = p;
              p = link[p];
            end
            link[slot] = p;
            if (prev < 0) head = slot;
            else link[prev] = slot;
          end
        end
        ACT_POP: begin
          n_pop++;
          if (head == NULL_LINK) begin
            r.status = ST_EMPTY;
            n_empty++;
          end else begin
            p = head;
            r.popped      = store[p];
            r.popped_slot = SLOT_W'(p);
            head    = link[p];
            used[p] = 1'b0;
            link[p] = NULL_LINK;
          end
        end
        ACT_FLUSH: begin
          n_flush++;
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            used[i] = 1'b0;
            link[i] = NULL_LINK;
          end
          head = NULL_LINK;
        end
        default: n_nop++;
      endcase
      cnt = 0;
      for (int i = 0; i < QUEUE_DEPTH; i++) cnt += used[i];
      r.head_valid = (head != NULL_LINK);
      r.head_slot  = r.head_valid ? SLOT_W'(head) : '0;
      r.used_count = CNT_W'(cnt);
      pending_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_response(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("result with no item outstanding: status %0h", got.status);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      n_checked++;
      compare_field("status", want.status, got.status);
      compare_field("popped_id", want.popped.id, got.popped.id);
      compare_field("popped_ext", want.popped.ext, got.popped.ext);
      compare_field("popped_remote", want.popped.remote, got.popped.remote);
      compare_field("popped_dlc", want.popped.dlc, got.popped.dlc);
      compare_field("popped_data", want.popped.data, got.popped.data);
      compare_field("popped_slot", want.popped_slot, got.popped_slot);
      compare_field("head_valid", want.head_valid, got.head_valid);
      compare_field("head_slot", want.head_slot, got.head_slot);
      compare_field("used_count", want.used_count, got.used_count);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_action = '0;
  logic [28:0]       in_msg_id = '0;
  logic              in_msg_ext = 1'b0;
  logic              in_msg_remote = 1'b0;
  logic [3:0]        in_msg_dlc = '0;
  logic [63:0]       in_msg_data = '0;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [28:0]       out_popped_id;
  logic              out_popped_ext;
  logic              out_popped_remote;
  logic [3:0]        out_popped_dlc;
  logic [63:0]       out_popped_data;
  logic [2:0]        out_popped_slot;
  logic              out_head_valid;
  logic [2:0]        out_head_slot;
  logic [3:0]        out_used_count;

  pool_mirror sb;
  int         quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  can_tx_sorted_queue u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_msg_id         (in_msg_id),
    .in_msg_ext        (in_msg_ext),
    .in_msg_remote     (in_msg_remote),
    .in_msg_dlc        (in_msg_dlc),
    .in_msg_data       (in_msg_data),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_popped_id     (out_popped_id),
    .out_popped_ext    (out_popped_ext),
    .out_popped_remote (out_popped_remote),
    .out_popped_dlc    (out_popped_dlc),
    .out_popped_data   (out_popped_data),
    .out_popped_slot   (out_popped_slot),
    .out_head_valid    (out_head_valid),
    .out_head_slot     (out_head_slot),
    .out_used_count    (out_used_count)
  );

  // Items and results are both taken at the edge, from values set up before it.
  always @(posedge clk) begin
    reply_t got;
    if (rst_n) begin
      if (start && !busy)
        sb.apply_request(action_t'(in_action),
                         {in_msg_id, in_msg_ext, in_msg_remote, in_msg_dlc, in_msg_data});
      if (out_valid) begin
        got.status      = status_t'(out_status);
        got.popped      = {out_popped_id, out_popped_ext, out_popped_remote,
                           out_popped_dlc, out_popped_data};
        got.popped_slot = out_popped_slot;
        got.head_valid  = out_head_valid;
        got.head_slot   = out_head_slot;
        got.used_count  = out_used_count;
        sb.match_response(got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIM) begin
          $display("can_tx_sorted_queue test failed");
          $finish;
        end
      end
    end
  end

  function automatic frame_t make_frame(logic [ID_W-1:0] id, logic ext, logic remote,
                                        logic [DLC_W-1:0] dlc, logic [DATA_W-1:0] data);
    frame_t f;
    f.id     = id;
    f.ext    = ext;
    f.remote = remote;
    f.dlc    = dlc;
    f.data   = data;
    return f;
  endfunction

  // Called at a rising edge; returns at the edge where the item was taken,
  // after any idle gap that follows it.
  task automatic queue_request(action_t act, frame_t f, int idle_pct);
    int gap;
    in_action     <= act;
    in_msg_id     <= f.id;
    in_msg_ext    <= f.ext;
    in_msg_remote <= f.remote;
    in_msg_dlc    <= f.dlc;
    in_msg_data   <= f.data;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Alternates between stretches that mostly fill the pool and stretches that
  // mostly drain it, so that full and empty are both reached often.
  task automatic run_phase(int n_items, int idle_pct);
    int      left, r;
    bit      filling;
    action_t act;
    frame_t  f;
    left = 0;
    filling = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      if (left == 0) begin
        filling = !filling;
        left = $urandom_range(10, 40);
      end
      left--;
      r = $urandom_range(0, 99);
      if (r < 2) act = ACT_FLUSH;
      else if (r < 4) act = ACT_NOP;
      else if (r < (filling ? 70 : 30)) act = ACT_INSERT;
      else act = ACT_POP;
      // A narrow identifier range makes equal identifiers common.
      case ($urandom_range(0, 9))
        0, 1, 2, 3: f.id = ID_W'($urandom_range(0, 7));
        4, 5:       f.id = ID_W'($urandom_range(0, 2047));
        6, 7:       f.id = ID_W'($urandom);
        8:          f.id = '0;
        default:    f.id = '1;
      endcase
      f.ext    = 1'($urandom_range(0, 1));
      f.remote = 1'($urandom_range(0, 1));
      f.dlc    = ($urandom_range(0, 4) == 0) ? DLC_W'($urandom_range(0, 15))
                                             : DLC_W'($urandom_range(0, 8));
      case ($urandom_range(0, 9))
        0:       f.data = '0;
        1:       f.data = '1;
        default: f.data = {$urandom, $urandom};
      endcase
      queue_request(act, f, idle_pct);
    end
  endtask

  initial begin
    int waited;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, no-op, extreme fields, equal identifiers, a full
    // pool, five pops in order, flush and a pop straight after it.
    queue_request(ACT_POP, make_frame('0, 0, 0, 0, '0), 0);
    queue_request(ACT_NOP, make_frame('1, 1, 1, 15, '1), 0);
    queue_request(ACT_INSERT, make_frame('1, 1, 1, 15, '1), 0);
    queue_request(ACT_INSERT, make_frame('0, 0, 0, 0, '0), 0);
    queue_request(ACT_INSERT, make_frame(29'h123, 0, 0, 8, 64'h0807060504030201), 0);
    queue_request(ACT_INSERT, make_frame(29'h123, 1, 0, 2, 64'hA5A5_5A5A_DEAD_BEEF), 0);
    queue_request(ACT_INSERT, make_frame(29'h7FF, 0, 1, 9, 64'h1122334455667788), 0);
    queue_request(ACT_INSERT, make_frame(29'h100, 1, 1, 4, 64'hFFFF_0000_FFFF_0000), 0);
    queue_request(ACT_INSERT, make_frame(29'h123, 0, 1, 7, 64'h0123456789ABCDEF), 0);
    queue_request(ACT_INSERT, make_frame('0, 1, 0, 1, 64'h8000_0000_0000_0001), 0);
    queue_request(ACT_INSERT, make_frame(29'h5, 0, 0, 3, 64'h5555_5555_5555_5555), 0);
    queue_request(ACT_NOP, make_frame('0, 0, 0, 0, '0), 0);
    for (int i = 0; i < 5; i++)
      queue_request(ACT_POP, make_frame('0, 0, 0, 0, '0), 0);
    queue_request(ACT_FLUSH, make_frame('0, 0, 0, 0, '0), 0);
    queue_request(ACT_POP, make_frame('0, 0, 0, 0, '0), 0);
    queue_request(ACT_INSERT, make_frame(29'h55, 1, 0, 8, 64'hCAFE_F00D_0000_FFFF), 0);
    queue_request(ACT_POP, make_frame('0, 0, 0, 0, '0), 0);
    queue_request(ACT_FLUSH, make_frame('0, 0, 0, 0, '0), 0);

    run_phase(PHASE_LEN, 0);
    run_phase(PHASE_LEN, 75);
    run_phase(PHASE_LEN, 0);
    run_phase(PHASE_LEN, 21);
    start <= 1'b0;

    waited = 0;
    while (sb.pending_replies.size() != 0 && waited < DRAIN_LIM) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);

    if (sb.pending_replies.size() != 0) begin
      $error("%0d results never arrived", sb.pending_replies.size());
      sb.mismatches++;
    end
    $display("Sent %0d inserts (%0d refused as full), %0d pops (%0d on an empty queue),",
             sb.n_insert, sb.n_full, sb.n_pop, sb.n_empty);
    $display("%0d flushes and %0d no-ops; %0d results checked, %0d mismatches.",
             sb.n_flush, sb.n_nop, sb.n_checked, sb.mismatches);
    if (sb.mismatches == 0)
      $display("can_tx_sorted_queue test passed");
    else
      $display("can_tx_sorted_queue test failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/ctsq_pkg.sv
design/ctsq_cell.sv
design/ctsq_slot_alloc.sv
design/can_tx_sorted_queue.sv
tb/sv/tb.sv
